@@ src/psc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the pressure compensation pipeline
// Field widths, internal datapath widths, calibration register indexes and
// the fixed constants of the second-order temperature compensation scheme.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Port field widths
  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int NUM_COEF   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int TEMP_W     = 19;
  localparam int PRES_W     = 25;

  // Internal datapath widths, sized from the value ranges of each term
  localparam int DIFF_W     = 25;  // D2 - C5*256
  localparam int MUL_W      = 42;  // diff times a 16-bit coefficient
  localparam int SQ_W       = 49;  // diff squared, never negative
  localparam int DEV_W      = 20;  // t1 - 2000
  localparam int LIN_W      = 36;  // first-order offset and sensitivity
  localparam int TI_W       = 17;  // second-order temperature term
  localparam int CSQ_W      = 35;  // squares of the temperature deviations
  localparam int CORR_W     = 39;  // second-order offset and sensitivity terms
  localparam int GD_W       = 40;  // corrected offset and sensitivity
  localparam int GD_LO_W    = 20;  // low slice of the split multiplication
  localparam int PL_W       = RAW_W + GD_LO_W;
  localparam int PH_W       = RAW_W + 1 + GD_W - GD_LO_W;
  localparam int PROD_W     = 64;
  localparam int Q1_W       = 44;
  localparam int X_W        = 45;
  localparam int MAG_W      = 32;
  localparam int RP_W       = 64;

  localparam int NUM_STAGES = 13;

  // Power-of-two scalings of the scheme
  localparam int SHIFT_REF   = 8;
  localparam int SHIFT_C2    = 16;
  localparam int SHIFT_C1    = 15;
  localparam int SHIFT_T     = 23;
  localparam int SHIFT_OFF   = 7;
  localparam int SHIFT_SENS  = 8;
  localparam int SHIFT_TI_LO = 33;
  localparam int SHIFT_TI_HI = 36;
  localparam int SHIFT_P1    = 21;
  localparam int SHIFT_P2    = 13;

  localparam int T_REF         = 2000;
  localparam int VLOW_OFFSET   = 3500;  // t1 < -1500 is the same as t1 - 2000 < -3500

  // Unsigned division by ten of a 32-bit value: multiply and take bits 35 up
  localparam logic [MAG_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;
  localparam int PQ_W          = RP_W - RECIP10_SHIFT;

  typedef logic [RAW_W-1:0]         raw_t;
  typedef logic [COEF_W-1:0]        coef_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [PRES_W-1:0] pres_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TEMP = 3'd2,
    REG_OFF_TEMP  = 3'd3,
    REG_REF_TEMP  = 3'd4,
    REG_TEMP_SENS = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

@@ src/psc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psc_if: handshake channels of the pressure compensation unit
// Reading input, result output and calibration write channels, each with
// valid, ready and payload, and a source and a sink modport.
// ----------------------------------------------------------------------------
interface psc_in_if;
  import psc_pkg::*;

  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface psc_out_if;
  import psc_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temperature_centi;
  pres_t pressure_value;

  modport source (output valid, output temperature_centi, output pressure_value, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_value, output ready);
endinterface

interface psc_cfg_if;
  import psc_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coef_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/pressure_sensor_compensation_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit: second-order pressure compensation
// Turns a raw pressure and temperature pair into a compensated temperature in
// centidegrees and a pressure figure, using six calibration words.
// ----------------------------------------------------------------------------
// Each reading passes through the register stages s0 to s12 in order.
// Throughput: one reading pair per cycle through 13 register stages while the output
// accepts; the stages advance independently, so bubbles close up while it stalls.
// Reset: synchronous; clears the stage valid bits and the calibration words.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit (
  input  logic   clk,
  input  logic   rst,
  psc_cfg_if.sink  cfg,
  psc_in_if.sink   reading,
  psc_out_if.source result
);
  import psc_pkg::*;

  // Calibration words
  coef_t sens_coefficient;
  coef_t offset_coefficient;
  coef_t sens_temp_coefficient;
  coef_t offset_temp_coefficient;
  coef_t reference_temperature;
  coef_t temp_sensitivity;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  // Stage registers
  raw_t                     s0_d1, s1_d1, s2_d1, s3_d1, s4_d1, s5_d1;
  logic signed [DIFF_W-1:0] s0_diff;
  logic signed [MUL_W-1:0]  s1_p_t, s1_p_off, s1_p_sens;
  logic [SQ_W-1:0]          s1_sq;
  logic signed [DEV_W-1:0]  s2_dev;
  logic signed [LIN_W-1:0]  s2_bias, s2_gain, s3_bias, s3_gain, s4_bias, s4_gain;
  logic [TI_W-1:0]          s2_ti_lo, s2_ti_hi;
  temp_t                    s3_t2, s4_t2, s5_t2, s6_t2, s7_t2, s8_t2, s9_t2;
  temp_t                    s10_t2, s11_t2, s12_t2;
  logic                     s3_low, s3_vlow, s4_low;
  logic [CSQ_W-1:0]         s3_dsq, s3_lsq;
  logic [CORR_W-1:0]        s4_bias_c, s4_gain_c;
  logic signed [GD_W-1:0]   s5_gdiff, s5_bdiff, s6_bdiff, s7_bdiff, s8_bdiff;
  logic [PL_W-1:0]          s6_pl;
  logic signed [PH_W-1:0]   s6_ph;
  logic signed [PROD_W-1:0] s7_prod;
  logic signed [Q1_W-1:0]   s8_q1;
  logic signed [X_W-1:0]    s9_x;
  logic                     s10_neg, s11_neg;
  logic [MAG_W-1:0]         s10_mag;
  logic [RP_W-1:0]          s11_rp;
  pres_t                    s12_pres;

  // Next values
  logic signed [DIFF_W-1:0]  diff_next;
  logic signed [MUL_W-1:0]   p_t_next, p_off_next, p_sens_next;
  logic signed [2*DIFF_W-1:0] sq_full;
  logic signed [MUL_W-1:0]   p_t_adj, p_t_quo, p_off_adj, p_off_quo, p_sens_adj, p_sens_quo;
  logic [SQ_W+1:0]           sq3;
  logic signed [DEV_W-1:0]   dev_next;
  logic signed [LIN_W-1:0]   bias_next, gain_next;
  logic [TI_W-1:0]           ti_lo_next, ti_hi_next;
  logic signed [DEV_W-1:0]   lo_dev;
  logic signed [2*DEV_W-1:0] dsq_full, lsq_full;
  logic signed [DEV_W:0]     t2_wide;
  logic [CORR_W-1:0]         dsq_e, lsq_e, bias_c_next, gain_c_next;
  logic signed [GD_W-1:0]    gdiff_next, bdiff_next;
  logic [PL_W-1:0]           pl_next;
  logic signed [PH_W-1:0]    ph_next;
  logic signed [PROD_W-1:0]  prod_next, prod_adj, prod_quo;
  logic signed [X_W-1:0]     x_next, x_adj, x_quo;
  logic signed [MAG_W-1:0]   q2;
  logic [MAG_W-1:0]          mag_next;
  logic [RP_W-1:0]           rp_next;
  logic [PQ_W-1:0]           pq;
  pres_t                     pres_next;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coefficient        <= '0;
      offset_coefficient      <= '0;
      sens_temp_coefficient   <= '0;
      offset_temp_coefficient <= '0;
      reference_temperature   <= '0;
      temp_sensitivity        <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SENS:      sens_coefficient        <= cfg.data;
        REG_OFFSET:    offset_coefficient      <= cfg.data;
        REG_SENS_TEMP: sens_temp_coefficient   <= cfg.data;
        REG_OFF_TEMP:  offset_temp_coefficient <= cfg.data;
        REG_REF_TEMP:  reference_temperature   <= cfg.data;
        REG_TEMP_SENS: temp_sensitivity        <= cfg.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || result.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign reading.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= reading.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // ------------------------------------------------ stage 0: temperature difference
  assign diff_next = $signed({1'b0, reading.raw_temperature})
                   - $signed({1'b0, reference_temperature, {SHIFT_REF{1'b0}}});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_d1   <= reading.raw_pressure;
      s0_diff <= diff_next;
    end
  end

  // ------------------------------------------------ stage 1: coefficient products
  assign p_t_next    = s0_diff * $signed({1'b0, temp_sensitivity});
  assign p_off_next  = s0_diff * $signed({1'b0, offset_temp_coefficient});
  assign p_sens_next = s0_diff * $signed({1'b0, sens_temp_coefficient});
  assign sq_full     = s0_diff * s0_diff;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1     <= s0_d1;
      s1_p_t    <= p_t_next;
      s1_p_off  <= p_off_next;
      s1_p_sens <= p_sens_next;
      s1_sq     <= sq_full[SQ_W-1:0];
    end
  end

  // ------------------------------------------------ stage 2: first-order terms
  // Truncation toward zero: negative values get 2^k-1 added before the shift.
  assign p_t_adj    = s1_p_t + MUL_W'({SHIFT_T{s1_p_t[MUL_W-1]}});
  assign p_t_quo    = p_t_adj >>> SHIFT_T;
  assign p_off_adj  = s1_p_off + MUL_W'({SHIFT_OFF{s1_p_off[MUL_W-1]}});
  assign p_off_quo  = p_off_adj >>> SHIFT_OFF;
  assign p_sens_adj = s1_p_sens + MUL_W'({SHIFT_SENS{s1_p_sens[MUL_W-1]}});
  assign p_sens_quo = p_sens_adj >>> SHIFT_SENS;

  assign dev_next  = p_t_quo[DEV_W-1:0];
  assign bias_next = LIN_W'({offset_coefficient, {SHIFT_C2{1'b0}}}) + p_off_quo[LIN_W-1:0];
  assign gain_next = LIN_W'({sens_coefficient, {SHIFT_C1{1'b0}}}) + p_sens_quo[LIN_W-1:0];

  // The square is never negative, so both scalings are plain shifts.
  assign sq3        = (SQ_W+2)'(s1_sq) + (SQ_W+2)'({s1_sq, 1'b0});
  assign ti_lo_next = sq3[SHIFT_TI_LO +: TI_W];
  assign ti_hi_next = TI_W'(s1_sq[SQ_W-1:SHIFT_TI_HI]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1    <= s1_d1;
      s2_dev   <= dev_next;
      s2_bias  <= bias_next;
      s2_gain  <= gain_next;
      s2_ti_lo <= ti_lo_next;
      s2_ti_hi <= ti_hi_next;
    end
  end

  // ------------------------------------------------ stage 3: branch and squares
  assign lo_dev   = s2_dev + DEV_W'(VLOW_OFFSET);
  assign dsq_full = s2_dev * s2_dev;
  assign lsq_full = lo_dev * lo_dev;
  assign t2_wide  = $signed({s2_dev[DEV_W-1], s2_dev}) + (DEV_W+1)'(T_REF)
                  - (DEV_W+1)'(s2_dev[DEV_W-1] ? s2_ti_lo : s2_ti_hi);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1   <= s2_d1;
      s3_t2   <= t2_wide[TEMP_W-1:0];
      s3_low  <= s2_dev[DEV_W-1];
      s3_vlow <= lo_dev[DEV_W-1];
      s3_dsq  <= dsq_full[CSQ_W-1:0];
      s3_lsq  <= lsq_full[CSQ_W-1:0];
      s3_bias <= s2_bias;
      s3_gain <= s2_gain;
    end
  end

  // ------------------------------------------------ stage 4: second-order corrections
  assign dsq_e = CORR_W'(s3_dsq);
  assign lsq_e = CORR_W'(s3_lsq);

  always_comb begin
    if (s3_low) begin
      bias_c_next = ((dsq_e + (dsq_e << 1)) >> 1)
                  + (s3_vlow ? ((lsq_e << 3) - lsq_e) : '0);
      gain_c_next = (((dsq_e << 2) + dsq_e) >> 3)
                  + (s3_vlow ? (lsq_e << 2) : '0);
    end else begin
      bias_c_next = dsq_e >> 4;
      gain_c_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1     <= s3_d1;
      s4_t2     <= s3_t2;
      s4_low    <= s3_low;
      s4_bias   <= s3_bias;
      s4_gain   <= s3_gain;
      s4_bias_c <= bias_c_next;
      s4_gain_c <= gain_c_next;
    end
  end

  // ------------------------------------------------ stage 5: corrected offset and sensitivity
  assign gdiff_next = GD_W'(s4_gain) - GD_W'(s4_gain_c);
  assign bdiff_next = GD_W'(s4_bias) - GD_W'(s4_bias_c);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1    <= s4_d1;
      s5_t2    <= s4_t2;
      s5_gdiff <= gdiff_next;
      s5_bdiff <= bdiff_next;
    end
  end

  // ------------------------------------------------ stage 6: split multiplication
  // D1 times the sensitivity is formed as two partial products.
  assign pl_next = s5_d1 * s5_gdiff[GD_LO_W-1:0];
  assign ph_next = $signed({1'b0, s5_d1}) * $signed(s5_gdiff[GD_W-1:GD_LO_W]);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_t2    <= s5_t2;
      s6_bdiff <= s5_bdiff;
      s6_pl    <= pl_next;
      s6_ph    <= ph_next;
    end
  end

  // ------------------------------------------------ stage 7: combine partial products
  assign prod_next = (PROD_W'(s6_ph) <<< GD_LO_W) + PROD_W'(s6_pl);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_t2    <= s6_t2;
      s7_bdiff <= s6_bdiff;
      s7_prod  <= prod_next;
    end
  end

  // ------------------------------------------------ stage 8: first scaling
  assign prod_adj = s7_prod + PROD_W'({SHIFT_P1{s7_prod[PROD_W-1]}});
  assign prod_quo = prod_adj >>> SHIFT_P1;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_t2    <= s7_t2;
      s8_bdiff <= s7_bdiff;
      s8_q1    <= prod_quo[Q1_W-1:0];
    end
  end

  // ------------------------------------------------ stage 9: subtract the offset
  assign x_next = X_W'(s8_q1) - X_W'(s8_bdiff);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_t2 <= s8_t2;
      s9_x  <= x_next;
    end
  end

  // ------------------------------------------------ stage 10: second scaling, magnitude
  assign x_adj    = s9_x + X_W'({SHIFT_P2{s9_x[X_W-1]}});
  assign x_quo    = x_adj >>> SHIFT_P2;
  assign q2       = x_quo[MAG_W-1:0];
  assign mag_next = s9_x[X_W-1] ? MAG_W'(-q2) : MAG_W'(q2);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_t2  <= s9_t2;
      s10_neg <= s9_x[X_W-1];
      s10_mag <= mag_next;
    end
  end

  // ------------------------------------------------ stage 11: reciprocal multiply by 1/10
  assign rp_next = s10_mag * RECIP10;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_t2  <= s10_t2;
      s11_neg <= s10_neg;
      s11_rp  <= rp_next;
    end
  end

  // ------------------------------------------------ stage 12: sign restore, output register
  assign pq        = s11_rp[RECIP10_SHIFT +: PQ_W];
  assign pres_next = s11_neg ? -PRES_W'(pq) : PRES_W'(pq);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_t2   <= s11_t2;
      s12_pres <= pres_next;
    end
  end

  assign result.valid             = v[NUM_STAGES-1];
  assign result.temperature_centi = s12_t2;
  assign result.pressure_value    = s12_pres;

  // ------------------------------------------------ assertions
  // The very-low branch is only ever a refinement of the low branch.
  a_vlow_in_low: assert property (@(posedge clk) disable iff (rst)
    v[3] && s3_vlow |-> s3_low)
    else $error("very-low branch flagged outside the low branch");

  // Above the threshold no sensitivity correction is applied.
  a_high_no_gain_c: assert property (@(posedge clk) disable iff (rst)
    v[4] && !s4_low |-> s4_gain_c == '0)
    else $error("sensitivity correction present in the high branch");

  // The scaled pressure magnitude must stay well inside the divider range.
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    v[10] |-> s10_mag[MAG_W-1:PRES_W+2] == '0)
    else $error("pressure magnitude out of range before division by ten");

  // A full pipeline with a stalled output must refuse new transactions.
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (&v) && !result.ready |-> !reading.ready)
    else $error("input accepted while every stage is occupied and stalled");

endmodule
`default_nettype wire

@@ tb/pressure_sensor_compensation_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit_test: self-checking bench for the unit
// Loads several calibration sets, including all-zero and all-ones, and sends
// corner readings, readings at the low and very-low temperature thresholds,
// and random readings. A scoreboard predicts each result and checks every
// result transaction in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit_test;
  import psc_pkg::*;

  localparam int    CLK_HALF_NS   = 5;
  localparam int    RESET_CYCLES  = 12;
  localparam int    LONG_HOLD     = 80;
  localparam int    DRAIN_MARGIN  = 20;
  localparam int    TIMEOUT_NS    = 3_000_000;
  localparam int    MAX_SHOWN     = 10;
  localparam raw_t  RAW_MAX       = '1;
  localparam coef_t COEF_MAX      = '1;
  localparam int    T_VERY_LOW    = -1500;
  // Indexes past the last calibration word; writes to them must be ignored.
  localparam cfg_idx_t UNUSED_REG_A = cfg_idx_t'(NUM_COEF);
  localparam cfg_idx_t UNUSED_REG_B = '1;

  typedef struct {
    temp_t temperature;
    pres_t pressure;
  } compensated_t;

  class compensation_scoreboard;
    coef_t        calib[NUM_COEF];
    compensated_t awaited_q[$];
    int unsigned  readings_noted;
    int unsigned  results_checked;
    int unsigned  failures;
    int unsigned  reports_shown;
    int unsigned  high_count;
    int unsigned  low_count;
    int unsigned  very_low_count;

    function new();
      foreach (calib[i]) calib[i] = '0;
    endfunction

    function void write_calibration(cfg_idx_t idx, coef_t value);
      if (idx < NUM_COEF) calib[idx] = value;
    endfunction

    function longint first_order_temp(raw_t d2);
      longint diff;
      diff = longint'(d2) - longint'(calib[REG_REF_TEMP]) * 256;
      return T_REF + diff * longint'(calib[REG_TEMP_SENS]) / 64'sd8388608;
    endfunction

    // Lowest raw temperature whose first-order temperature reaches the target.
    function raw_t raw_temp_for(longint target);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = longint'(RAW_MAX);
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (first_order_temp(raw_t'(mid)) >= target) hi = mid;
        else lo = mid + 1;
      end
      return raw_t'(lo);
    endfunction

    function compensated_t compensate(raw_t d1_raw, raw_t d2_raw);
      longint d1, c1, c2, c3, c4, c5;
      longint diff, t1, bias, gain, ti, bias_c, gain_c, dev, lo, t2, p2;
      compensated_t r;
      d1 = longint'(d1_raw);
      c1 = longint'(calib[REG_SENS]);
      c2 = longint'(calib[REG_OFFSET]);
      c3 = longint'(calib[REG_SENS_TEMP]);
      c4 = longint'(calib[REG_OFF_TEMP]);
      c5 = longint'(calib[REG_REF_TEMP]);
      diff = longint'(d2_raw) - c5 * 256;
      t1 = first_order_temp(d2_raw);
      bias = c2 * 65536 + c4 * diff / 128;
      gain = c1 * 32768 + c3 * diff / 256;
      dev = t1 - T_REF;
      if (t1 < T_REF) begin
        ti = 3 * diff * diff / 64'sd8589934592;
        bias_c = 3 * dev * dev / 2;
        gain_c = 5 * dev * dev / 8;
        if (t1 < T_VERY_LOW) begin
          lo = t1 - T_VERY_LOW;
          bias_c += 7 * lo * lo;
          gain_c += 4 * lo * lo;
          very_low_count++;
        end else begin
          low_count++;
        end
      end else begin
        ti = 2 * diff * diff / 64'sd137438953472;
        bias_c = dev * dev / 16;
        gain_c = 0;
        high_count++;
      end
      t2 = t1 - ti;
      p2 = ((d1 * (gain - gain_c) / 2097152 - (bias - bias_c)) / 8192) / 10;
      r.temperature = temp_t'(t2);
      r.pressure = pres_t'(p2);
      return r;
    endfunction

    function void note_reading(raw_t d1, raw_t d2);
      awaited_q.push_back(compensate(d1, d2));
      readings_noted++;
    endfunction

    function void check_result(temp_t temperature, pres_t pressure);
      compensated_t exp_r;
      if (awaited_q.size() == 0) begin
        failures++;
        if (reports_shown < MAX_SHOWN)
          $display("unexpected result transaction: temperature %0d pressure %0d",
                   temperature, pressure);
        reports_shown++;
        return;
      end
      exp_r = awaited_q.pop_front();
      results_checked++;
      if (exp_r.temperature !== temperature || exp_r.pressure !== pressure) begin
        failures++;
        if (reports_shown < MAX_SHOWN)
          $display("result %0d wrong: temperature expected %0d got %0d, pressure expected %0d got %0d",
                   results_checked, exp_r.temperature, temperature,
                   exp_r.pressure, pressure);
        reports_shown++;
      end
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void close_out();
      if (awaited_q.size() != 0) begin
        failures++;
        $display("%0d results never arrived", awaited_q.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  psc_cfg_if cfg_ch ();
  psc_in_if  reading_ch ();
  psc_out_if result_ch ();

  pressure_sensor_compensation_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .reading (reading_ch),
    .result  (result_ch)
  );

  compensation_scoreboard sb = new();

  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int unsigned stall_cycle  = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned settings_loaded = 0;
  int unsigned register_writes = 0;
  raw_t        ref_point;
  raw_t        edge_2000;
  raw_t        edge_1500;

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("pressure_sensor_compensation_unit_test: FAIL");
    $finish;
  end

  // Receiver: cycles through stall styles, with a long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      stall_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case ((stall_cycle / 97) % 4)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= ($urandom_range(0, 7) != 0);
          default: result_ch.ready <= ((stall_cycle % 11) >= 4);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_ch.valid && result_ch.ready)
          sb.check_result(result_ch.temperature_centi, result_ch.pressure_value);
        if (reading_ch.valid && !reading_ch.ready) backpressure_cycles++;
      end
    end
  end

  task automatic write_register(cfg_idx_t idx, coef_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_calibration(idx, value);
    register_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Only called with the pipeline empty. Also works out temperature targets.
  task automatic load_calibration(input coef_t setting[NUM_COEF]);
    write_register(UNUSED_REG_A, coef_t'($urandom));
    for (int i = 0; i < NUM_COEF; i++) write_register(cfg_idx_t'(i), setting[i]);
    write_register(UNUSED_REG_B, coef_t'($urandom));
    settings_loaded++;
    ref_point = raw_t'(setting[REG_REF_TEMP] * 256);
    edge_2000 = sb.raw_temp_for(T_REF);
    edge_1500 = sb.raw_temp_for(T_VERY_LOW);
  endtask

  task automatic offer_reading(raw_t pressure, raw_t temperature);
    @(negedge clk);
    reading_ch.valid           <= 1'b1;
    reading_ch.raw_pressure    <= pressure;
    reading_ch.raw_temperature <= temperature;
    do @(posedge clk); while (!reading_ch.ready);
    sb.note_reading(pressure, temperature);
  endtask

  task automatic pause_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      reading_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic raw_t near(raw_t centre, int span);
    longint v;
    v = longint'(centre) - span;
    v += $urandom_range(0, 2 * span);
    if (v < 0) v = 0;
    if (v > longint'(RAW_MAX)) v = longint'(RAW_MAX);
    return raw_t'(v);
  endfunction

  function automatic coef_t random_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEF_MAX;
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic stream_readings(int count, bit gapless);
    int   burst_left;
    raw_t p;
    raw_t t;
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < count; n++) begin
      if (!gapless && burst_left == 0) begin
        pause_input($urandom_range(1, 9));
        burst_left = $urandom_range(1, 24);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = raw_t'($urandom);
        4, 5:       t = near(ref_point, 4096);
        6:          t = near(edge_2000, 32);
        7:          t = near(edge_1500, 32);
        8:          t = near(edge_1500, 200000);
        default:    t = $urandom_range(0, 1) ? near(RAW_MAX, 2) : near('0, 2);
      endcase
      case ($urandom_range(0, 4))
        0:       p = $urandom_range(0, 1) ? RAW_MAX : '0;
        1:       p = raw_t'($urandom_range(0, 255));
        default: p = raw_t'($urandom);
      endcase
      offer_reading(p, t);
      burst_left--;
    end
  endtask

  initial begin
    coef_t cal[NUM_COEF];
    reading_ch.valid           = 1'b0;
    reading_ch.raw_pressure    = '0;
    reading_ch.raw_temperature = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    ref_point = '0;
    edge_2000 = '0;
    edge_1500 = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Calibration words straight out of reset are all zero.
    offer_reading('0, '0);
    offer_reading(RAW_MAX, RAW_MAX);
    drain_results();

    cal[REG_SENS]      = 16'd40127;
    cal[REG_OFFSET]    = 16'd36924;
    cal[REG_SENS_TEMP] = 16'd23317;
    cal[REG_OFF_TEMP]  = 16'd23282;
    cal[REG_REF_TEMP]  = 16'd33464;
    cal[REG_TEMP_SENS] = 16'd28312;
    load_calibration(cal);
    offer_reading('0, '0);
    offer_reading(RAW_MAX, '0);
    offer_reading('0, RAW_MAX);
    offer_reading(RAW_MAX, RAW_MAX);
    offer_reading(raw_t'(6465444), ref_point);
    // Exactly on and just below both temperature thresholds.
    offer_reading(raw_t'(6465444), edge_2000);
    offer_reading(raw_t'(6465444), edge_2000 - 1'b1);
    offer_reading(RAW_MAX, edge_1500);
    offer_reading(RAW_MAX, edge_1500 - 1'b1);
    stream_readings(100, 1'b0);
    // Long receiver hold-off while readings keep coming, to fill the pipeline.
    hold_request = 1'b1;
    stream_readings(60, 1'b1);
    drain_results();
    stream_readings(100, 1'b0);
    drain_results();

    foreach (cal[i]) cal[i] = COEF_MAX;
    load_calibration(cal);
    offer_reading('0, '0);
    offer_reading(RAW_MAX, '0);
    offer_reading('0, RAW_MAX);
    offer_reading(RAW_MAX, RAW_MAX);
    stream_readings(120, 1'b0);
    drain_results();

    foreach (cal[i]) cal[i] = '0;
    load_calibration(cal);
    stream_readings(60, 1'b0);
    drain_results();

    repeat (7) begin
      foreach (cal[i]) cal[i] = random_coef();
      load_calibration(cal);
      stream_readings(125, 1'b0);
      drain_results();
    end

    repeat (DRAIN_MARGIN) @(posedge clk);
    sb.close_out();
    $display("Covered %0d readings and %0d results over %0d calibration sets (%0d writes).",
             sb.readings_noted, sb.results_checked, settings_loaded, register_writes);
    $display("Branches: %0d high, %0d low, %0d very low; %0d cycles of input back-pressure.",
             sb.high_count, sb.low_count, sb.very_low_count, backpressure_cycles);
    if (sb.failures == 0) begin
      $display("pressure_sensor_compensation_unit_test: PASS");
    end else begin
      $display("pressure_sensor_compensation_unit_test: FAIL");
    end
    $finish;
  end

endmodule
